>>> design/fir_filter_warmup_macros.svh
// Assertion macros for the FIR filter with warm-up guard.
// Used by fir_filter_warmup.sv; expects clk_i and rst_ni in scope.
`ifndef FIR_FILTER_WARMUP_MACROS_SVH
`define FIR_FILTER_WARMUP_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define FFW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fir_filter_warmup: assertion failed");
// Condition must never be true outside reset.
`define FFW_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("fir_filter_warmup: forbidden condition seen");
`else
`define FFW_ASSERT(lbl, prop)
`define FFW_ASSERT_NEVER(lbl, cond)
`endif

`endif

>>> design/ffw_pkg.sv
// Shared constants and types for the FIR filter with warm-up guard.
// Used by fir_filter_warmup.sv; no dependencies.
package ffw_pkg;

  // Sizing
  localparam int MAX_TAPS       = 32;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_W         = 18;
  localparam int OUT_W          = 24;
  localparam int TC_W           = 6;   // tap_count register width
  localparam int TIDX_W         = 5;   // tap_index field width

  // Derived widths
  localparam int ADDR_W = $clog2(MAX_TAPS);
  localparam int PTR_W  = ADDR_W + 1;          // holds wptr + MAX_TAPS - j
  localparam int CNT_W  = $clog2(MAX_TAPS + 1); // counts up to MAX_TAPS
  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  localparam int ACC_W  = PROD_W + ADDR_W;

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

endpackage

>>> design/fir_filter_warmup.sv
// Direct-form FIR filter with warm-up guard. A load word writes one Q3.14
// tap. When the filter is warm, a sample word passes through accept, read,
// multiply, accumulate and result stages, with one shared multiply-accumulate
// walking the taps, fed from two registered-read RAMs; while warming it goes
// straight to the result stage. It waits longer while an earlier result still
// waits in the output register. The input stalls for the whole of a sample's
// work; the result sits in an output register, so words are taken while it
// waits. Depends on ffw_pkg, ffw_ram and fir_filter_warmup_macros.svh.
`include "fir_filter_warmup_macros.svh"

module fir_filter_warmup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: tap_count
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ffw_pkg::TC_W-1:0]            cfg_data_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic                                first_i,
  input  logic signed [ffw_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [ffw_pkg::TIDX_W-1:0]          tap_index_i,
  input  logic signed [ffw_pkg::COEF_W-1:0]   tap_value_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ffw_pkg::OUT_W-1:0]    filtered_o,
  output logic                                saturated_o,
  output logic                                warming_o
);

  localparam int ADDR_W = ffw_pkg::ADDR_W;
  localparam int PTR_W  = ffw_pkg::PTR_W;
  localparam int CNT_W  = ffw_pkg::CNT_W;
  localparam int ACC_W  = ffw_pkg::ACC_W;
  localparam int OUT_W  = ffw_pkg::OUT_W;
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  ffw_pkg::state_e state_q, state_d;

  logic [ffw_pkg::TC_W-1:0] tap_count_q;
  logic [ADDR_W-1:0]        wptr_q, wptr_d;
  logic [CNT_W-1:0]         seen_q, seen_d;
  logic [CNT_W-1:0]         j_q, j_d;
  logic [CNT_W-1:0]         taps;
  logic                     warm_q, warm_d;
  logic                     rd_v_q, rd_v_d;
  logic                     mul_v_q;

  logic signed [ffw_pkg::PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]                acc_q, acc_d;
  logic signed [ffw_pkg::SAMPLE_BITS-1:0] samp_rd;
  logic signed [ffw_pkg::COEF_W-1:0]      coef_rd;

  logic                     in_acc, smp_acc, load_acc;
  logic                     coef_we;
  logic [ADDR_W-1:0]        rd_addr;
  logic [PTR_W-1:0]         pos_raw;
  logic                     out_free;

  logic                     out_valid_q;
  logic signed [OUT_W-1:0]  filtered_q;
  logic                     saturated_q;
  logic                     warming_q;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [OUT_W-1:0]  res_val;
  logic                     res_sat;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ffw_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign smp_acc     = in_acc && (req_type_i == ffw_pkg::REQ_SAMPLE);
  assign load_acc    = in_acc && (req_type_i == ffw_pkg::REQ_LOAD);
  assign coef_we     = load_acc && (32'(tap_index_i) < ffw_pkg::MAX_TAPS);
  assign out_free    = !out_valid_q || !out_stall_i;

  // Taps in use: zero acts as one, above the store depth clamps
  always_comb begin
    if (tap_count_q == '0) begin
      taps = CNT_W'(1);
    end else if (32'(tap_count_q) > ffw_pkg::MAX_TAPS) begin
      taps = CNT_W'(ffw_pkg::MAX_TAPS);
    end else begin
      taps = CNT_W'(tap_count_q);
    end
  end

  // Delay-line read position: wptr - j modulo the depth
  always_comb begin
    pos_raw = PTR_W'(wptr_q) + PTR_W'(ffw_pkg::MAX_TAPS) - PTR_W'(j_q);
    if (32'(pos_raw) >= ffw_pkg::MAX_TAPS) begin
      rd_addr = ADDR_W'(pos_raw - PTR_W'(ffw_pkg::MAX_TAPS));
    end else begin
      rd_addr = ADDR_W'(pos_raw);
    end
  end

  // Coefficient and delay-line stores
  ffw_ram #(.WIDTH(ffw_pkg::COEF_W), .DEPTH(ffw_pkg::MAX_TAPS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (ADDR_W'(tap_index_i)),
    .wdata_i (tap_value_i),
    .raddr_i (ADDR_W'(j_q)),
    .rdata_o (coef_rd)
  );

  ffw_ram #(.WIDTH(ffw_pkg::SAMPLE_BITS), .DEPTH(ffw_pkg::MAX_TAPS)) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (smp_acc),
    .waddr_i (wptr_q),
    .wdata_i (sample_i),
    .raddr_i (rd_addr),
    .rdata_o (samp_rd)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    wptr_d  = wptr_q;
    seen_d  = seen_q;
    j_d     = j_q;
    warm_d  = warm_q;
    rd_v_d  = 1'b0;
    acc_d   = acc_q;
    if (mul_v_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
    case (state_q)
      ffw_pkg::S_IDLE: begin
        if (smp_acc) begin
          if (first_i) begin
            seen_d = CNT_W'(1);
          end else if (32'(seen_q) < ffw_pkg::MAX_TAPS) begin
            seen_d = seen_q + CNT_W'(1);
          end
          warm_d  = (seen_d < taps);
          j_d     = '0;
          acc_d   = '0;
          state_d = warm_d ? ffw_pkg::S_DONE : ffw_pkg::S_RUN;
        end
      end
      ffw_pkg::S_RUN: begin
        // issue one tap read per cycle
        rd_v_d = 1'b1;
        j_d    = j_q + CNT_W'(1);
        if (j_q == taps - CNT_W'(1)) begin
          state_d = ffw_pkg::S_DRAIN;
        end
      end
      ffw_pkg::S_DRAIN: begin
        if (!rd_v_q && !mul_v_q) begin
          state_d = ffw_pkg::S_DONE;
        end
      end
      ffw_pkg::S_DONE: begin
        if (out_free) begin
          wptr_d  = (32'(wptr_q) == ffw_pkg::MAX_TAPS - 1) ? '0 : wptr_q + ADDR_W'(1);
          state_d = ffw_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ffw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffw_pkg::S_IDLE;
      tap_count_q <= ffw_pkg::TC_W'(1);
      wptr_q      <= '0;
      seen_q      <= '0;
      j_q         <= '0;
      warm_q      <= 1'b0;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tap_count_q <= cfg_data_i;
      end
      wptr_q  <= wptr_d;
      seen_q  <= seen_d;
      j_q     <= j_d;
      warm_q  <= warm_d;
      rd_v_q  <= rd_v_d;
      mul_v_q <= rd_v_q;
    end
  end

  // Multiply stage and accumulator
  always_ff @(posedge clk_i) begin
    prod_q <= samp_rd * coef_rd;
    acc_q  <= acc_d;
  end

  // Floor shift and saturation; the result is forced to zero while warming
  always_comb begin
    shifted = acc_q >>> ffw_pkg::COEF_FRAC_BITS;
    res_sat = 1'b0;
    if (shifted > SAT_HI) begin
      res_val = OUT_W'(SAT_HI);
      res_sat = 1'b1;
    end else if (shifted < SAT_LO) begin
      res_val = OUT_W'(SAT_LO);
      res_sat = 1'b1;
    end else begin
      res_val = OUT_W'(shifted);
    end
    if (warm_q) begin
      res_val = '0;
      res_sat = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ffw_pkg::S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ffw_pkg::S_DONE && out_free) begin
      filtered_q  <= res_val;
      saturated_q <= res_sat;
      warming_q   <= warm_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign saturated_o = saturated_q;
  assign warming_o   = warming_q;

  // Checks
  `FFW_ASSERT(a_warm_zero, out_valid_o && warming_o |-> filtered_o == '0 && !saturated_o)
  `FFW_ASSERT(a_sat_rail, out_valid_o && saturated_o |-> filtered_o == OUT_W'(SAT_HI) || filtered_o == OUT_W'(SAT_LO))
  `FFW_ASSERT(a_sample_busy, smp_acc |=> state_q != ffw_pkg::S_IDLE)
  `FFW_ASSERT_NEVER(a_read_outside_run, rd_v_q && !$past(state_q == ffw_pkg::S_RUN))

endmodule

>>> design/ffw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
